>>> hdl/tcb_pkg.sv
// Shared types, constants and helpers for the countdown timer bank.
// Used by tcb_cell and multi_channel_countdown_timer_bank_core; depends on nothing.
`default_nettype none

package tcb_pkg;

  // Bank size; only the lowest sixteen timers can be addressed by a command
  localparam int NUM_TIMERS = 16;
  localparam int CUR_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  localparam int COUNT_W = 11;
  localparam int DUR_W   = 16;
  localparam int TICK_W  = 32;
  localparam int TIDX_W  = 4;

  // duration_ms / 50 as a multiply by a rounded-up reciprocal (2^22 / 50)
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 22;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 17'd83887;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_START = 2'd1,
    MODE_STOP  = 2'd2,
    MODE_QUERY = 2'd3
  } mode_t;

  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } state_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [TIDX_W-1:0] timer_index;
    logic [DUR_W-1:0]  duration_ms;
    logic              notify_enable;
  } cmd_word_t;

  typedef struct packed {
    logic              result_kind;
    logic [TIDX_W-1:0] event_timer;
    logic              expired;
    logic [TICK_W-1:0] ticks_elapsed;
    logic              last;
  } result_word_t;

  // Broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic load;
    logic clear;
    logic tick;
    logic shift;
  } cell_ctrl_t;

  // Ticks for a duration: floor(ms / 50) + 1, exact over the full 16-bit range
  function automatic logic [COUNT_W-1:0] ticks_for_ms(input logic [DUR_W-1:0] ms);
    logic [DUR_W+RECIP_W-1:0] prod;
    prod = {{RECIP_W{1'b0}}, ms} * {{DUR_W{1'b0}}, RECIP_MUL};
    return prod[RECIP_SHIFT +: COUNT_W] + COUNT_W'(1);
  endfunction

endpackage

`default_nettype wire

>>> hdl/tcb_cell.sv
// One timer cell: count, notify flag and an expiry token passed up the chain.
// Depends on tcb_pkg for widths and the control struct.
`default_nettype none

module tcb_cell (
  input  wire                          clk,
  input  wire                          rst,
  input  tcb_pkg::cell_ctrl_t          ctrl,
  input  wire                          sel,
  input  wire [tcb_pkg::COUNT_W-1:0]   load_count,
  input  wire                          load_notify,
  input  wire                          ev_in,
  output logic                         ev_out,
  output logic                         zero
);
  import tcb_pkg::*;

  logic [COUNT_W-1:0] count;
  logic               notify;
  logic               ev;

  // Load, clear or count down; raise the token when a notifying count runs out
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      notify <= 1'b0;
      ev     <= 1'b0;
    end else begin
      if (ctrl.load && sel) begin
        count  <= load_count;
        notify <= load_notify;
      end else if (ctrl.clear && sel) begin
        count  <= '0;
        notify <= 1'b0;
      end else if (ctrl.tick && count != '0) begin
        count <= count - COUNT_W'(1);
      end

      if (ctrl.tick) begin
        ev <= (count == COUNT_W'(1)) && notify;
      end else if (ctrl.shift) begin
        ev <= ev_in;
      end
    end
  end

  assign ev_out = ev;
  assign zero   = (count == '0);

endmodule

`default_nettype wire

>>> hdl/multi_channel_countdown_timer_bank_core.sv
// Top level of the countdown timer bank: command decode, walk sequencer, cell chain.
// Depends on tcb_pkg and tcb_cell.
`default_nettype none

// A command word is taken when start is high and busy is low. Start and stop
// leave busy low and give no result. A query's reply shows on result with
// result_valid high in the next cycle. A tick decrements all timers at once,
// then walks the expiry tokens up the chain of cells, one cell per cycle from
// the highest index down; busy stays high during the walk, ending as soon as
// no token is left. Each expiry event is one cycle on result; the receiver
// must take it then, and the word of the final event of a tick has last set.
module multi_channel_countdown_timer_bank_core (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  output logic                   busy,
  input  tcb_pkg::cmd_word_t     cmd,
  output logic                   result_valid,
  output tcb_pkg::result_word_t  result
);
  import tcb_pkg::*;

  state_t             state, state_next;
  cell_ctrl_t         ctrl;
  logic               accept;
  logic [NUM_TIMERS-1:0] sel;
  logic [NUM_TIMERS-1:0] ev_vec;
  logic [NUM_TIMERS-1:0] zero_vec;
  logic               ev_top;
  logic               ev_rest;
  logic               query_expired;
  logic [COUNT_W-1:0] load_count;
  logic [TICK_W-1:0]  tick_counter;
  logic [CUR_W-1:0]   cur_idx;
  logic               result_valid_next;
  result_word_t       result_next;

  assign accept     = start && !busy;
  assign load_count = ticks_for_ms(cmd.duration_ms);
  assign ev_top     = ev_vec[NUM_TIMERS-1];
  assign ev_rest    = |ev_vec[NUM_TIMERS-2:0];

  // Decode the addressed timer; out-of-range indexes select nothing
  always_comb begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      sel[i] = (32'(cmd.timer_index) == i);
    end
  end

  // Query: expired unless the addressed timer still counts
  always_comb begin
    query_expired = 1'b1;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (sel[i] && !zero_vec[i]) query_expired = 1'b0;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && cmd.mode == MODE_TICK) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (!ev_rest) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    busy = 1'b0;
    ctrl = '0;
    unique case (state)
      ST_IDLE: begin
        ctrl.tick  = start && cmd.mode == MODE_TICK;
        ctrl.load  = start && cmd.mode == MODE_START;
        ctrl.clear = start && cmd.mode == MODE_STOP;
      end
      ST_WALK: begin
        busy       = 1'b1;
        ctrl.shift = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  // Chain of cells; tokens move toward the highest index
  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    tcb_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .sel         (sel[g]),
      .load_count  (load_count),
      .load_notify (cmd.notify_enable),
      .ev_in       ((g == 0) ? 1'b0 : ev_vec[(g == 0) ? 0 : g-1]),
      .ev_out      (ev_vec[g]),
      .zero        (zero_vec[g])
    );
  end

  // Build the next result word
  always_comb begin
    result_valid_next = 1'b0;
    result_next       = result;
    if (state == ST_WALK && ev_top) begin
      result_valid_next         = 1'b1;
      result_next.result_kind   = KIND_EVENT;
      result_next.event_timer   = TIDX_W'(cur_idx);
      result_next.expired       = 1'b1;
      result_next.ticks_elapsed = tick_counter;
      result_next.last          = !ev_rest;
    end else if (accept && cmd.mode == MODE_QUERY) begin
      result_valid_next         = 1'b1;
      result_next.result_kind   = KIND_QUERY;
      result_next.event_timer   = cmd.timer_index;
      result_next.expired       = query_expired;
      result_next.ticks_elapsed = tick_counter;
      result_next.last          = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      tick_counter <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
      if (accept && cmd.mode == MODE_TICK) tick_counter <= tick_counter + TICK_W'(1);
    end
  end

  // Payload registers: walk index and result word
  always_ff @(posedge clk) begin
    if (accept && cmd.mode == MODE_TICK) begin
      cur_idx <= CUR_W'(NUM_TIMERS - 1);
    end else if (state == ST_WALK) begin
      cur_idx <= cur_idx - CUR_W'(1);
    end
    result <= result_next;
  end

`ifndef SYNTHESIS
  a_tick_walks: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.mode == MODE_TICK) |=> busy)
    else $error("tick accepted without entering the walk");

  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(state) == ST_WALK) || $past(accept && cmd.mode == MODE_QUERY))
    else $error("result word without a tick walk or query");

  a_event_expired: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.result_kind == KIND_EVENT) |-> result.expired)
    else $error("expiry event not marked expired");

  a_walk_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && !ev_rest) |=> !busy)
    else $error("walk continues with no token left");
`endif

endmodule

`default_nettype wire

>>> dv/multi_channel_countdown_timer_bank_core_test.sv
// Self-checking testbench for multi_channel_countdown_timer_bank_core.
// Drives tick, start, stop and query words and checks every result against a local prediction.
// Depends on tcb_pkg and the RTL of the timer bank.

module multi_channel_countdown_timer_bank_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tcb_pkg::*;

  localparam int MS_PER_TICK = 50;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PER_PHASE = 123;
  localparam int EXPIRY_TARGET = 48;

  // Tracks the timer bank state and holds the results it should produce
  class countdown_scoreboard;
    logic [COUNT_W-1:0] remaining [NUM_TIMERS];
    logic               notify_on [NUM_TIMERS];
    logic [TICK_W-1:0]  tick_count;
    result_word_t       pending_results [$];
    int unsigned        errors;
    int unsigned        expiries_due;

    function new();
      for (int i = 0; i < NUM_TIMERS; i++) begin
        remaining[i] = '0;
        notify_on[i] = 1'b0;
      end
      tick_count = '0;
      errors = 0;
      expiries_due = 0;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // Update the bank for one accepted word and queue the results it causes
    function void note_command(cmd_word_t w);
      result_word_t r;
      int first;
      bit in_bank;
      first = pending_results.size();
      in_bank = int'(w.timer_index) < NUM_TIMERS;
      case (mode_t'(w.mode))
        MODE_TICK: begin
          tick_count = tick_count + 1'b1;
          for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
            if (remaining[i] != '0) begin
              remaining[i] = remaining[i] - 1'b1;
              if (remaining[i] == '0 && notify_on[i] && i < 16) begin
                r.result_kind   = KIND_EVENT;
                r.event_timer   = TIDX_W'(i);
                r.expired       = 1'b1;
                r.ticks_elapsed = tick_count;
                r.last          = 1'b0;
                pending_results.push_back(r);
                expiries_due++;
              end
            end
          end
          // mark the final event of this tick
          if (pending_results.size() > first) begin
            r = pending_results.pop_back();
            r.last = 1'b1;
            pending_results.push_back(r);
          end
        end
        MODE_START: begin
          if (in_bank) begin
            remaining[w.timer_index] = COUNT_W'(int'(w.duration_ms) / MS_PER_TICK + 1);
            notify_on[w.timer_index] = w.notify_enable;
          end
        end
        MODE_STOP: begin
          if (in_bank) begin
            remaining[w.timer_index] = '0;
            notify_on[w.timer_index] = 1'b0;
          end
        end
        default: begin
          r.result_kind   = KIND_QUERY;
          r.event_timer   = w.timer_index;
          r.expired       = !(in_bank && remaining[w.timer_index] != '0);
          r.ticks_elapsed = tick_count;
          r.last          = 1'b1;
          pending_results.push_back(r);
        end
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one result word with the oldest queued one
    function void check_result(result_word_t got);
      result_word_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("result_kind", want.result_kind, got.result_kind);
      compare_field("event_timer", want.event_timer, got.event_timer);
      compare_field("expired", want.expired, got.expired);
      compare_field("ticks_elapsed", want.ticks_elapsed, got.ticks_elapsed);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         start = 1'b0;
  cmd_word_t    cmd = '0;
  logic         busy;
  logic         result_valid;
  result_word_t result;

  int unsigned  idle_pct = 0;
  int unsigned  cycle_count = 0;
  countdown_scoreboard board = new();

  multi_channel_countdown_timer_bank_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result)
  );

  always #5 clk = ~clk;

  // Note accepted words and check result words at each edge
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) board.note_command(cmd);
      if (result_valid) board.check_result(result);
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("multi_channel_countdown_timer_bank_core: mismatch");
      $finish;
    end
  end

  function automatic cmd_word_t make_cmd(mode_t m, int idx, int dur, bit ntf);
    cmd_word_t w;
    w.mode          = m;
    w.timer_index   = TIDX_W'(idx);
    w.duration_ms   = DUR_W'(dur);
    w.notify_enable = ntf;
    return w;
  endfunction

  // Mostly short durations so timers expire often; a few span the full range
  function automatic cmd_word_t random_cmd();
    int pick;
    int dur;
    mode_t m;
    pick = $urandom_range(99);
    if (pick < 42) m = MODE_TICK;
    else if (pick < 72) m = MODE_START;
    else if (pick < 82) m = MODE_STOP;
    else m = MODE_QUERY;
    if ($urandom_range(99) < 85) dur = $urandom_range(499);
    else dur = $urandom_range(65535);
    return make_cmd(m, $urandom_range(15), dur, $urandom_range(1));
  endfunction

  // Present one word, idling at random first, and hold it until accepted
  task automatic send_word(cmd_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      cmd <= cmd_word_t'($urandom);
      @(posedge clk);
    end
    start <= 1'b1;
    cmd <= w;
    do @(posedge clk); while (busy);
  endtask

  // Hold off until every queued result has come out
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Arm all sixteen timers to fire on the same tick
  task automatic full_fanout();
    for (int i = 0; i < 16; i++) send_word(make_cmd(MODE_START, i, $urandom_range(49), 1'b1));
    send_word(make_cmd(MODE_TICK, 0, 0, 1'b0));
  endtask

  initial begin
    int extra;
    extra = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset state, shortest and longest durations, silent expiry, stop
    send_word(make_cmd(MODE_QUERY, 0, 0, 1'b0));
    send_word(make_cmd(MODE_TICK, 0, 0, 1'b0));
    send_word(make_cmd(MODE_START, 15, 0, 1'b1));
    send_word(make_cmd(MODE_START, 0, 49, 1'b1));
    send_word(make_cmd(MODE_START, 7, 50, 1'b0));
    send_word(make_cmd(MODE_START, 3, 65535, 1'b1));
    send_word(make_cmd(MODE_QUERY, 15, 0, 1'b0));
    send_word(make_cmd(MODE_TICK, 0, 0, 1'b0));
    send_word(make_cmd(MODE_QUERY, 7, 0, 1'b0));
    send_word(make_cmd(MODE_TICK, 0, 0, 1'b0));
    send_word(make_cmd(MODE_QUERY, 7, 0, 1'b0));
    send_word(make_cmd(MODE_QUERY, 3, 0, 1'b0));
    send_word(make_cmd(MODE_STOP, 3, 0, 1'b0));
    send_word(make_cmd(MODE_QUERY, 3, 0, 1'b0));
    send_word(make_cmd(MODE_STOP, 9, 65535, 1'b1));
    send_word(make_cmd(MODE_START, 5, 100, 1'b1));
    send_word(make_cmd(MODE_START, 5, 149, 1'b1));
    send_word(make_cmd(MODE_STOP, 5, 0, 1'b0));
    send_word(make_cmd(MODE_TICK, 0, 0, 1'b0));
    send_word(make_cmd(MODE_QUERY, 5, 0, 1'b0));
    drain_results();

    // random: sender idles 15%, then 86%, then never
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 15 : (phase == 1) ? 86 : 0;
      full_fanout();
      for (int k = 0; k < RANDOM_PER_PHASE - 17; k++) begin
        send_word(random_cmd());
        if (k == RANDOM_PER_PHASE / 2) drain_results();
      end
    end

    // keep going until enough expiry events have been produced
    while (board.expiries_due < EXPIRY_TARGET && extra < 2000) begin
      send_word(random_cmd());
      extra++;
    end

    start <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("multi_channel_countdown_timer_bank_core: match");
    end else begin
      $display("multi_channel_countdown_timer_bank_core: mismatch");
    end
    $finish;
  end

endmodule
